// File: src/psm_pkg.sv
// Shared types and constants of the packed slot map.
package psm_pkg;

	localparam int CAPACITY = 64;
	localparam int REC_W    = 64;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = SLOT_W + 1;
	localparam int QDEPTH   = 2;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_UPDATE = 2'd1,
		OP_REMOVE = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_UNKNOWN = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_CLEAN   = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		ES_IDLE,
		ES_EXEC,
		ES_SCAN,
		ES_FLOUT
	} eng_state_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] handle;
		logic [REC_W-1:0]  record;
	} item_t;

	typedef struct packed {
		stat_t             status;
		logic [SLOT_W-1:0] handle;
		logic [SLOT_W-1:0] slot;
		logic [REC_W-1:0]  record;
		logic              last;
	} res_t;

endpackage

// File: src/psm_front.sv
// Front end: accepts beats, decodes the operation and queues them for the engine.
module psm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    func,
	input  logic [5:0]    handle,
	input  logic [63:0]   record,
	output logic          q_valid,
	output psm_pkg::item_t q_item,
	input  logic          q_pop
);
	import psm_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);

	item_t            mem_q [QDEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [PTR_W:0]   cnt_q;
	logic             push, pop;
	item_t            in_item;

	assign in_ready = (cnt_q != (PTR_W+1)'(QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_comb begin
		in_item.op     = op_t'(func);
		in_item.handle = handle[SLOT_W-1:0];
		in_item.record = record[REC_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/psm_back.sv
// Engine: holds the tables, carries out each queued operation and drives the result register.
module psm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  psm_pkg::item_t q_item,
	output logic           q_pop,
	output logic           res_valid,
	output psm_pkg::res_t  res,
	input  logic           res_ready
);
	import psm_pkg::*;

	eng_state_t state_q, state_d;
	item_t      cur_q;

	logic [SLOT_W-1:0] soh_mem [CAPACITY];
	logic [SLOT_W-1:0] hos_mem [CAPACITY];
	logic [REC_W-1:0]  rec_mem [CAPACITY];
	logic [SLOT_W-1:0] fh_mem  [CAPACITY];

	logic [SLOT_W-1:0] soh_rd_q, hos_rd_q, fh_rd_q;
	logic [REC_W-1:0]  rec_rd_q;

	logic [CAPACITY-1:0] live_q, dirty_q;
	logic [CNT_W-1:0]    count_q, free_top_q, fresh_q;
	logic [SLOT_W-1:0]   idx_q;

	logic              out_free, rd_en, emit, last_dirty;
	logic [SLOT_W-1:0] row_ra, soh_ra, fh_ra;
	res_t              res_d;
	logic              soh_we, hos_we, rec_we, fh_we;
	logic [SLOT_W-1:0] soh_wa, soh_wd, hos_wa, hos_wd, rec_wa, fh_wa, fh_wd;
	logic [REC_W-1:0]  rec_wd;
	logic              dirty_set, dirty_clr, live_set, live_clr;
	logic [SLOT_W-1:0] dirty_a, live_a;
	logic              cnt_inc, cnt_dec, ft_inc, ft_dec, fresh_inc, idx_clr, idx_inc;
	logic [SLOT_W-1:0] new_h;
	logic [CAPACITY-1:0] above;

	assign out_free   = !res_valid || res_ready;
	assign above      = (dirty_q >> idx_q) >> 1;
	assign last_dirty = (above == '0);
	assign new_h      = (free_top_q != '0) ? fh_rd_q : fresh_q[SLOT_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ES_IDLE: begin
				if (q_valid) state_d = ES_EXEC;
			end
			ES_EXEC: begin
				if (cur_q.op == OP_FLUSH && dirty_q != '0) state_d = ES_SCAN;
				else if (out_free) state_d = ES_IDLE;
			end
			ES_SCAN: begin
				if (dirty_q[idx_q]) state_d = ES_FLOUT;
			end
			ES_FLOUT: begin
				// After each flushed beat the walk resumes from the next slot.
				if (out_free) state_d = last_dirty ? ES_IDLE : ES_SCAN;
			end
			default: state_d = ES_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		rd_en     = 1'b0;
		soh_ra    = q_item.handle;
		row_ra    = SLOT_W'(count_q - 1'b1);
		fh_ra     = SLOT_W'(free_top_q - 1'b1);
		emit      = 1'b0;
		res_d     = '0;
		soh_we    = 1'b0; soh_wa = '0; soh_wd = '0;
		hos_we    = 1'b0; hos_wa = '0; hos_wd = '0;
		rec_we    = 1'b0; rec_wa = '0; rec_wd = '0;
		fh_we     = 1'b0; fh_wa  = free_top_q[SLOT_W-1:0]; fh_wd = cur_q.handle;
		dirty_set = 1'b0; dirty_clr = 1'b0; dirty_a = '0;
		live_set  = 1'b0; live_clr  = 1'b0; live_a  = '0;
		cnt_inc   = 1'b0; cnt_dec = 1'b0; ft_inc = 1'b0; ft_dec = 1'b0;
		fresh_inc = 1'b0; idx_clr = 1'b0; idx_inc = 1'b0;
		case (state_q)
			ES_IDLE: begin
				q_pop = q_valid;
				rd_en = q_valid;
			end
			ES_EXEC: begin
				res_d.last   = 1'b1;
				res_d.status = STAT_OK;
				case (cur_q.op)
					OP_ADD: begin
						emit = out_free;
						if (count_q == CNT_W'(CAPACITY)) begin
							res_d.status = STAT_FULL;
						end else begin
							res_d.handle = new_h;
							res_d.slot   = count_q[SLOT_W-1:0];
							soh_we = emit; soh_wa = new_h; soh_wd = count_q[SLOT_W-1:0];
							hos_we = emit; hos_wa = count_q[SLOT_W-1:0]; hos_wd = new_h;
							rec_we = emit; rec_wa = count_q[SLOT_W-1:0]; rec_wd = cur_q.record;
							dirty_set = emit; dirty_a = count_q[SLOT_W-1:0];
							live_set  = emit; live_a  = new_h;
							cnt_inc   = emit;
							ft_dec    = emit && (free_top_q != '0);
							fresh_inc = emit && (free_top_q == '0);
						end
					end
					OP_UPDATE: begin
						emit = out_free;
						res_d.handle = cur_q.handle;
						if (!live_q[cur_q.handle]) begin
							res_d.status = STAT_UNKNOWN;
						end else begin
							res_d.slot = soh_rd_q;
							rec_we = emit; rec_wa = soh_rd_q; rec_wd = cur_q.record;
							dirty_set = emit; dirty_a = soh_rd_q;
						end
					end
					OP_REMOVE: begin
						emit = out_free;
						res_d.handle = cur_q.handle;
						if (!live_q[cur_q.handle] || count_q == '0) begin
							res_d.status = STAT_UNKNOWN;
						end else begin
							// The last slot's record and owner move down into the vacated slot.
							res_d.slot = soh_rd_q;
							rec_we = emit; rec_wa = soh_rd_q; rec_wd = rec_rd_q;
							soh_we = emit; soh_wa = hos_rd_q; soh_wd = soh_rd_q;
							hos_we = emit; hos_wa = soh_rd_q; hos_wd = hos_rd_q;
							live_clr  = emit; live_a = cur_q.handle;
							dirty_set = emit; dirty_a = soh_rd_q;
							cnt_dec   = emit;
							fh_we     = emit && (free_top_q != CNT_W'(CAPACITY));
							ft_inc    = fh_we;
						end
					end
					OP_FLUSH: begin
						if (dirty_q == '0) begin
							emit = out_free;
							res_d.status = STAT_CLEAN;
						end else begin
							idx_clr = 1'b1;
						end
					end
					default: ;
				endcase
			end
			ES_SCAN: begin
				row_ra = idx_q;
				if (dirty_q[idx_q]) rd_en = 1'b1;
				else idx_inc = 1'b1;
			end
			ES_FLOUT: begin
				emit = out_free;
				res_d.status = STAT_OK;
				res_d.handle = hos_rd_q;
				res_d.slot   = idx_q;
				res_d.record = rec_rd_q;
				res_d.last   = last_dirty;
				dirty_clr = emit; dirty_a = idx_q;
				idx_inc   = emit && !last_dirty;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			soh_rd_q <= soh_mem[soh_ra];
			hos_rd_q <= hos_mem[row_ra];
			rec_rd_q <= rec_mem[row_ra];
			fh_rd_q  <= fh_mem[fh_ra];
		end
		if (soh_we) soh_mem[soh_wa] <= soh_wd;
		if (hos_we) hos_mem[hos_wa] <= hos_wd;
		if (rec_we) rec_mem[rec_wa] <= rec_wd;
		if (fh_we)  fh_mem[fh_wa]   <= fh_wd;
		if (q_pop)  cur_q <= q_item;
		if (emit)   res   <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ES_IDLE;
			live_q     <= '0;
			dirty_q    <= '0;
			count_q    <= '0;
			free_top_q <= '0;
			fresh_q    <= '0;
			idx_q      <= '0;
			res_valid  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (live_set) live_q[live_a] <= 1'b1;
			if (live_clr) live_q[live_a] <= 1'b0;
			if (dirty_set) dirty_q[dirty_a] <= 1'b1;
			if (dirty_clr) dirty_q[dirty_a] <= 1'b0;
			if (cnt_inc) count_q <= count_q + 1'b1;
			if (cnt_dec) count_q <= count_q - 1'b1;
			if (ft_inc) free_top_q <= free_top_q + 1'b1;
			if (ft_dec) free_top_q <= free_top_q - 1'b1;
			if (fresh_inc) fresh_q <= fresh_q + 1'b1;
			if (idx_clr) idx_q <= '0;
			else if (idx_inc) idx_q <= idx_q + 1'b1;
			if (emit) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
		end
	end

endmodule

// File: src/packed_slot_map.sv
// Top level of the packed slot map.
// Records live densely in slots behind stable handles. A two-beat queue takes operations
// while the engine works; results leave through one output register. Add, update and
// remove each go through the engine as a registered table read, then the write.
// Flush walks up from slot 0, skipping clean slots and reading each dirty one up to the
// highest, one result per dirty slot; a flush with nothing dirty gives one result.
// The engine holds while the output register is full and not taken.
module packed_slot_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [5:0]  handle,
	input  logic [63:0] record,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [5:0]  out_handle,
	output logic [5:0]  slot,
	output logic [63:0] out_record,
	output logic        last
);
	import psm_pkg::*;

	logic  q_valid, q_pop;
	item_t q_item;
	res_t  res;

	psm_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .func, .handle, .record,
		.q_valid, .q_item, .q_pop
	);

	psm_back u_back (
		.clk, .arst_n, .q_valid, .q_item, .q_pop,
		.res_valid(out_valid), .res, .res_ready(out_ready)
	);

	assign status     = res.status;
	assign out_handle = res.handle;
	assign slot       = res.slot;
	assign out_record = res.record;
	assign last       = res.last;

endmodule

// File: src/psm_checker.sv
// Port-level checks of the packed slot map, bound to the top level.
module psm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [5:0]  out_handle,
	input logic [5:0]  slot,
	input logic [63:0] out_record,
	input logic        last
);
	import psm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot)
		&& $stable(out_record) && $stable(last))
		else $error("result changed while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> last)
		else $error("error result not final");

	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_CLEAN |-> out_handle == '0 && slot == '0
		&& out_record == '0)
		else $error("clean flush result not zero");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> out_handle == '0 && slot == '0
		&& out_record == '0)
		else $error("full result not zero");

endmodule

bind packed_slot_map psm_checker u_psm_checker (.*);

// File: tb/sv/tb_packed_slot_map.sv
`timescale 1ns / 1ps
// Self-checking testbench for the packed slot map: predicted table operations and flushes.
module tb_packed_slot_map;
	import psm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [5:0]  handle;
	logic [63:0] record;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [5:0]  out_handle;
	logic [5:0]  slot;
	logic [63:0] out_record;
	logic        last;

	packed_slot_map dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .handle(handle), .record(record),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .out_handle(out_handle), .slot(slot),
		.out_record(out_record), .last(last)
	);

	// Predicted copy of the table.
	logic [5:0]  map_slot [CAPACITY];
	bit          map_live [CAPACITY];
	logic [5:0]  map_owner [CAPACITY];
	logic [63:0] map_rec [CAPACITY];
	bit          map_dirty [CAPACITY];
	logic [5:0]  spare_stack [CAPACITY];
	int          spare_top;
	int          next_fresh;
	int          live_n;

	res_t        pending_q [$];
	int          mismatches;
	int          results_seen;
	int          flushes_done;
	int          idle_cycles;
	bit          calm;
	bit          hold_rx;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic res_t mk_res(stat_t st, logic [5:0] h, logic [5:0] s,
		logic [63:0] r, logic l);
		res_t x;
		x.status = st;
		x.handle = h;
		x.slot   = s;
		x.record = r;
		x.last   = l;
		return x;
	endfunction

	task automatic predict_op(op_t op, logic [5:0] h, logic [63:0] r);
		int s;
		int top;
		int n;
		case (op)
			OP_ADD: begin
				if (live_n >= CAPACITY) begin
					pending_q.push_back(mk_res(STAT_FULL, '0, '0, '0, 1'b1));
				end else begin
					if (spare_top > 0) begin
						spare_top--;
						h = spare_stack[spare_top];
					end else begin
						h = next_fresh[5:0];
						next_fresh++;
					end
					s = live_n;
					live_n++;
					map_slot[h] = s[5:0];
					map_live[h] = 1'b1;
					map_owner[s] = h;
					map_rec[s] = r;
					map_dirty[s] = 1'b1;
					pending_q.push_back(mk_res(STAT_OK, h, s[5:0], '0, 1'b1));
				end
			end
			OP_UPDATE: begin
				if (!map_live[h]) begin
					pending_q.push_back(mk_res(STAT_UNKNOWN, h, '0, '0, 1'b1));
				end else begin
					s = map_slot[h];
					map_rec[s] = r;
					map_dirty[s] = 1'b1;
					pending_q.push_back(mk_res(STAT_OK, h, s[5:0], '0, 1'b1));
				end
			end
			OP_REMOVE: begin
				if (!map_live[h] || live_n == 0) begin
					pending_q.push_back(mk_res(STAT_UNKNOWN, h, '0, '0, 1'b1));
				end else begin
					s = map_slot[h];
					live_n--;
					top = live_n;
					map_rec[s] = map_rec[top];
					map_slot[map_owner[top]] = s[5:0];
					map_owner[s] = map_owner[top];
					map_live[h] = 1'b0;
					if (spare_top < CAPACITY) begin
						spare_stack[spare_top] = h;
						spare_top++;
					end
					map_dirty[s] = 1'b1;
					pending_q.push_back(mk_res(STAT_OK, h, s[5:0], '0, 1'b1));
				end
			end
			default: begin
				n = 0;
				for (int i = 0; i < CAPACITY; i++) begin
					if (map_dirty[i]) begin
						pending_q.push_back(mk_res(STAT_OK, map_owner[i], i[5:0],
							map_rec[i], 1'b0));
						map_dirty[i] = 1'b0;
						n++;
					end
				end
				if (n == 0)
					pending_q.push_back(mk_res(STAT_CLEAN, '0, '0, '0, 1'b1));
				else
					pending_q[$].last = 1'b1;
				flushes_done++;
			end
		endcase
	endtask

	// Offers one beat, with an optional random gap first, and predicts it on acceptance.
	// Valid stays high from one beat to the next unless a gap is taken.
	task automatic send_op(op_t op, logic [5:0] h, logic [63:0] r);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		handle   <= h;
		record   <= r;
		do @(posedge clk); while (!in_ready);
		predict_op(op, h, r);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got %h, expected %h", what, got, want);
		mismatches++;
	endtask

	// Result checker.
	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected beat", 64'(out_handle), '0);
			end else begin
				e = pending_q.pop_front();
				if (status != e.status)
					report_mismatch("status", 64'(status), 64'(e.status));
				if (out_handle != e.handle)
					report_mismatch("out_handle", 64'(out_handle), 64'(e.handle));
				if (slot != e.slot)
					report_mismatch("slot", 64'(slot), 64'(e.slot));
				if (out_record != e.record)
					report_mismatch("out_record", out_record, e.record);
				if (last != e.last)
					report_mismatch("last", 64'(last), 64'(e.last));
			end
		end
	end

	// Receiver stalls in random bursts, or a long hold when asked.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				out_ready <= 1'b0;
				@(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Watchdog on cycles with no beat on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("timeout with %0d results outstanding", pending_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [5:0] live_handle();
		logic [5:0] h;
		if (live_n == 0)
			return 6'($urandom_range(0, 63));
		h = map_owner[$urandom_range(0, live_n - 1)];
		return h;
	endfunction

	function automatic logic [63:0] rand_rec();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_directed();
		send_op(OP_FLUSH, '0, '0);
		send_op(OP_UPDATE, 6'd63, '1);
		send_op(OP_REMOVE, 6'd0, '0);
		send_op(OP_ADD, '0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_op(OP_ADD, 6'd63, 64'h0);
		send_op(OP_ADD, '0, 64'hA5A5_5A5A_0F0F_F0F0);
		send_op(OP_UPDATE, 6'd1, 64'h5A5A_A5A5_F0F0_0F0F);
		send_op(OP_FLUSH, '0, '0);
		// Removing the last slot copies onto itself and leaves the slot dirty.
		send_op(OP_REMOVE, 6'd2, '0);
		// Removing the lowest slot moves the top record down; freed handle reused LIFO.
		send_op(OP_REMOVE, 6'd0, '0);
		send_op(OP_UPDATE, 6'd0, 64'h1);
		send_op(OP_FLUSH, '0, '0);
		send_op(OP_ADD, '0, 64'h2);
		send_op(OP_ADD, '0, 64'h3);
		send_op(OP_FLUSH, '0, '0);
		send_op(OP_FLUSH, '0, '0);
	endtask

	task automatic test_fill_full();
		while (live_n < CAPACITY)
			send_op(OP_ADD, '0, rand_rec());
		send_op(OP_ADD, '0, rand_rec());
		send_op(OP_FLUSH, '0, '0);
		repeat (6) send_op(OP_REMOVE, live_handle(), '0);
	endtask

	// The receiver stops for a long stretch while operations keep coming.
	task automatic test_backpressure();
		hold_rx = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_rx = 1'b0;
			end
			begin
				repeat (8) send_op(OP_UPDATE, live_handle(), rand_rec());
				send_op(OP_FLUSH, '0, '0);
			end
		join
	endtask

	task automatic test_random(int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			if (i == count * 3 / 4)
				calm = 1'b1;
			pick = $urandom_range(0, 9);
			if (pick < 3)
				send_op(OP_ADD, 6'($urandom_range(0, 63)), rand_rec());
			else if (pick < 6)
				send_op(OP_UPDATE, ($urandom_range(0, 4) == 0) ?
					6'($urandom_range(0, 63)) : live_handle(), rand_rec());
			else if (pick < 9)
				send_op(OP_REMOVE, ($urandom_range(0, 4) == 0) ?
					6'($urandom_range(0, 63)) : live_handle(), '0);
			else
				send_op(OP_FLUSH, '0, '0);
		end
		send_op(OP_FLUSH, '0, '0);
	endtask

	initial begin
		in_valid = 1'b0;
		func = OP_ADD;
		handle = '0;
		record = '0;
		arst_n = 1'b0;
		mismatches = 0;
		results_seen = 0;
		flushes_done = 0;
		idle_cycles = 0;
		calm = 1'b0;
		hold_rx = 1'b0;
		spare_top = 0;
		next_fresh = 0;
		live_n = 0;
		for (int i = 0; i < CAPACITY; i++) begin
			map_live[i] = 1'b0;
			map_dirty[i] = 1'b0;
			map_slot[i] = '0;
			map_owner[i] = '0;
			map_rec[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_full();
		test_backpressure();
		test_random(12);
		in_valid <= 1'b0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered add, update, remove and flush, a full table, unknown handles,");
		$display("a long output stall; %0d results checked over %0d flushes.",
			results_seen, flushes_done);
		if (mismatches == 0 && pending_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
